/* src/mfap_pkg.sv */
// Shared types and constants of the maximum-flow block.
`default_nettype none
package mfap_pkg;

  localparam int VERT_W  = 4;
  localparam int VERT_N  = 1 << VERT_W;
  localparam int CAP_W   = 16;
  localparam int ADDR_W  = 2 * VERT_W;
  localparam int TOTAL_W = 20;
  localparam int SCAN_W  = VERT_W + 1;
  localparam int BN_W    = CAP_W + 1;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [CAP_W-1:0]   CAP_MAX   = {CAP_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [BN_W-1:0]    BN_START  = {1'b1, {CAP_W{1'b0}}};

  typedef logic [ADDR_W-1:0] cap_addr_t;
  typedef logic [CAP_W-1:0]  cap_t;

  // Write request and clear strobe toward the capacity memory.
  typedef struct packed {
    logic      we;
    cap_addr_t addr;
    cap_t      data;
    logic      clr;
  } cap_wr_t;

  function automatic cap_t sat_add(input cap_t a, input cap_t b);
    logic [CAP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CAP_W] ? CAP_MAX : s[CAP_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/mfap_cap_mem.sv */
// Residual-capacity memory with a registered read port and per-entry valid bits.
`default_nettype none
module mfap_cap_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mfap_pkg::cap_wr_t wr,
  input  wire mfap_pkg::cap_addr_t raddr,
  output mfap_pkg::cap_t         rdata
);
  import mfap_pkg::*;

  cap_t                mem [VERT_N*VERT_N];
  logic [VERT_N*VERT_N-1:0] vld_r;
  cap_t                rd_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_r <= mem[raddr];
  end

  // An entry that was never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule
`default_nettype wire

/* src/max_flow_augmenting_path.sv */
// Maximum flow by depth-first augmenting paths over a 16-vertex capacity memory.
// All steps share one read port: add-edge reads, then writes the saturating sum; clear
// strobes the memory. Compute: each search takes a setup step, a read and a check per
// unvisited neighbor probed, a step per visited neighbor skipped or level backed out, and
// per path a bottleneck step, a read, forward and reverse write per edge, a closing step.
// Synchronous active-low reset clears the control state and marks the matrix all zero.
`default_nettype none
module max_flow_augmenting_path (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_from_vertex,
  input  wire logic [3:0]  in_to_vertex,
  input  wire logic [15:0] in_edge_capacity,
  input  wire logic [3:0]  in_source_vertex,
  input  wire logic [3:0]  in_sink_vertex,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [19:0]      out_flow_total
);
  import mfap_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ED_WR  = 4'd1;
  localparam logic [3:0] ST_SINIT  = 4'd2;
  localparam logic [3:0] ST_SC_RD  = 4'd3;
  localparam logic [3:0] ST_SC_CK  = 4'd4;
  localparam logic [3:0] ST_AUG    = 4'd5;
  localparam logic [3:0] ST_AUG_RD = 4'd6;
  localparam logic [3:0] ST_AUG_FW = 4'd7;
  localparam logic [3:0] ST_AUG_RV = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [VERT_W-1:0]  src_r, src_nxt, dst_r, dst_nxt;
  logic [VERT_W-1:0]  ea_r, ea_nxt, eb_r, eb_nxt;
  cap_t               ecap_r, ecap_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [VERT_N-1:0]  visited_r, visited_nxt;
  logic [VERT_W-1:0]  depth_r, depth_nxt;
  logic [VERT_W-1:0]  cur_v_r, cur_v_nxt;
  logic [SCAN_W-1:0]  cur_scan_r, cur_scan_nxt;
  logic [BN_W-1:0]    cur_bn_r, cur_bn_nxt;

  // Search stack below the current top; the top lives in the cur_* registers.
  logic [VERT_W-1:0]  stk_v_r    [VERT_N];
  logic [SCAN_W-1:0]  stk_scan_r [VERT_N];
  logic [BN_W-1:0]    stk_bn_r   [VERT_N];
  logic               push;
  logic [VERT_W-1:0]  depth_dn;

  cap_wr_t            wr;
  cap_addr_t          raddr;
  cap_t               rdata;
  logic [TOTAL_W:0]   tsum;
  logic [VERT_W-1:0]  scan_u;

  mfap_cap_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_flow_total = total_r;
  assign depth_dn       = depth_r - 1'b1;
  assign scan_u         = cur_scan_r[VERT_W-1:0];
  assign tsum           = {1'b0, total_r} + {{(TOTAL_W+1-CAP_W){1'b0}}, ecap_r};

  always_comb begin
    state_nxt    = state_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    ea_nxt       = ea_r;
    eb_nxt       = eb_r;
    ecap_nxt     = ecap_r;
    total_nxt    = total_r;
    visited_nxt  = visited_r;
    depth_nxt    = depth_r;
    cur_v_nxt    = cur_v_r;
    cur_scan_nxt = cur_scan_r;
    cur_bn_nxt   = cur_bn_r;
    push         = 1'b0;
    wr           = '0;
    raddr        = {cur_v_r, scan_u};

    case (state_r)
      ST_IDLE: begin
        raddr = {in_from_vertex, in_to_vertex};
        if (in_valid) begin
          case (in_cmd)
            CMD_ADD: begin
              ea_nxt    = in_from_vertex;
              eb_nxt    = in_to_vertex;
              ecap_nxt  = in_edge_capacity;
              state_nxt = ST_ED_WR;
            end
            CMD_COMPUTE: begin
              src_nxt   = in_source_vertex;
              dst_nxt   = in_sink_vertex;
              total_nxt = '0;
              state_nxt = (in_source_vertex == in_sink_vertex) ? ST_OUT : ST_SINIT;
            end
            CMD_CLEAR: begin
              wr.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ED_WR: begin
        wr.we     = 1'b1;
        wr.addr   = {ea_r, eb_r};
        wr.data   = sat_add(rdata, ecap_r);
        state_nxt = ST_IDLE;
      end

      ST_SINIT: begin
        visited_nxt        = '0;
        visited_nxt[src_r] = 1'b1;
        depth_nxt          = '0;
        cur_v_nxt          = src_r;
        cur_scan_nxt       = '0;
        cur_bn_nxt         = BN_START;
        state_nxt          = ST_SC_RD;
      end

      ST_SC_RD: begin
        if (cur_scan_r[VERT_W]) begin
          // Neighbors exhausted: back up one level, or stop when at the source.
          if (depth_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            depth_nxt    = depth_dn;
            cur_v_nxt    = stk_v_r[depth_dn];
            cur_scan_nxt = stk_scan_r[depth_dn];
            cur_bn_nxt   = stk_bn_r[depth_dn];
          end
        end else if (visited_r[scan_u]) begin
          cur_scan_nxt = cur_scan_r + 1'b1;
        end else begin
          state_nxt = ST_SC_CK;
        end
      end

      ST_SC_CK: begin
        cur_scan_nxt = cur_scan_r + 1'b1;
        state_nxt    = ST_SC_RD;
        if (rdata != '0) begin
          if (&depth_r) begin
            // The stack is full; this level is abandoned.
            cur_scan_nxt = {1'b1, {VERT_W{1'b0}}};
          end else begin
            push         = 1'b1;
            depth_nxt    = depth_r + 1'b1;
            cur_v_nxt    = scan_u;
            cur_scan_nxt = '0;
            cur_bn_nxt   = ({1'b0, rdata} < cur_bn_r) ? {1'b0, rdata} : cur_bn_r;
            if (scan_u == dst_r) begin
              state_nxt = ST_AUG;
            end else begin
              visited_nxt[scan_u] = 1'b1;
            end
          end
        end
      end

      ST_AUG: begin
        ecap_nxt  = cur_bn_r[CAP_W-1:0];
        state_nxt = ST_AUG_RD;
      end

      ST_AUG_RD: begin
        if (depth_r == '0) begin
          total_nxt = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
          state_nxt = ST_SINIT;
        end else begin
          ea_nxt    = stk_v_r[depth_dn];
          raddr     = {stk_v_r[depth_dn], cur_v_r};
          state_nxt = ST_AUG_FW;
        end
      end

      ST_AUG_FW: begin
        wr.we     = 1'b1;
        wr.addr   = {ea_r, cur_v_r};
        wr.data   = rdata - ecap_r;
        raddr     = {cur_v_r, ea_r};
        state_nxt = ST_AUG_RV;
      end

      ST_AUG_RV: begin
        wr.we     = 1'b1;
        wr.addr   = {cur_v_r, ea_r};
        wr.data   = sat_add(rdata, ecap_r);
        cur_v_nxt = ea_r;
        depth_nxt = depth_dn;
        state_nxt = ST_AUG_RD;
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      total_r   <= '0;
      visited_r <= '0;
      depth_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      visited_r <= visited_nxt;
      depth_r   <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    ecap_r     <= ecap_nxt;
    cur_v_r    <= cur_v_nxt;
    cur_scan_r <= cur_scan_nxt;
    cur_bn_r   <= cur_bn_nxt;
    if (push) begin
      stk_v_r[depth_r]    <= cur_v_r;
      stk_scan_r[depth_r] <= cur_scan_r + 1'b1;
      stk_bn_r[depth_r]   <= cur_bn_r;
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the maximum-flow block: random edge loads, clears and flow computes.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import mfap_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Scoreboard: keeps a private copy of the capacity matrix and predicts
  // each flow total from the input transfers that the block has accepted.
  class flow_scoreboard;
    int unsigned cap_matrix [VERT_N][VERT_N];
    logic [TOTAL_W-1:0] pending_totals [$];
    int errors;
    int flows_checked;

    function new();
      errors = 0;
      flows_checked = 0;
      foreach (cap_matrix[i, j]) cap_matrix[i][j] = 0;
    endfunction

    // One depth-first search with neighbors tried in ascending order. The
    // bottleneck found is pushed through the matrix and returned; zero means
    // that no path is left.
    function int unsigned push_one_path(int src, int dst);
      bit seen [VERT_N];
      int stack_v [VERT_N];
      int next_u [VERT_N];
      int unsigned bneck [VERT_N];
      int depth;
      int v;
      int a;
      int b;
      bit moved;
      depth = 0;
      foreach (seen[i]) seen[i] = 0;
      stack_v[0] = src;
      next_u[0] = 0;
      bneck[0] = 1 << 30;
      seen[src] = 1;
      forever begin
        v = stack_v[depth];
        if (v == dst) begin
          for (int i = 0; i < depth; i++) begin
            a = stack_v[i];
            b = stack_v[i+1];
            cap_matrix[a][b] -= bneck[depth];
            cap_matrix[b][a] += bneck[depth];
            if (cap_matrix[b][a] > CAP_MAX) cap_matrix[b][a] = CAP_MAX;
          end
          return bneck[depth];
        end
        moved = 0;
        for (int u = next_u[depth]; u < VERT_N; u++) begin
          if (seen[u] || cap_matrix[v][u] == 0) continue;
          next_u[depth] = u + 1;
          if (depth + 1 >= VERT_N) break;
          depth++;
          stack_v[depth] = u;
          next_u[depth] = 0;
          bneck[depth] = (cap_matrix[v][u] < bneck[depth-1]) ?
                         cap_matrix[v][u] : bneck[depth-1];
          if (u != dst) seen[u] = 1;
          moved = 1;
          break;
        end
        if (!moved) begin
          if (depth == 0) return 0;
          depth--;
        end
      end
    endfunction

    function void note_input(logic [1:0] cmd, logic [3:0] fv, logic [3:0] tv,
                             logic [15:0] cap, logic [3:0] sv, logic [3:0] kv);
      int unsigned total;
      int unsigned f;
      total = 0;
      case (cmd)
        CMD_ADD: begin
          cap_matrix[fv][tv] += cap;
          if (cap_matrix[fv][tv] > CAP_MAX) cap_matrix[fv][tv] = CAP_MAX;
        end
        CMD_CLEAR: begin
          foreach (cap_matrix[i, j]) cap_matrix[i][j] = 0;
        end
        CMD_COMPUTE: begin
          if (sv != kv) begin
            forever begin
              f = push_one_path(sv, kv);
              if (f == 0) break;
              total += f;
              if (total > TOTAL_MAX) total = TOTAL_MAX;
            end
          end
          pending_totals = {pending_totals, total[TOTAL_W-1:0]};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [TOTAL_W-1:0] flow);
      logic [TOTAL_W-1:0] want;
      if (pending_totals.size() == 0) begin
        $error("flow_total: result %0d arrived with no compute pending", flow);
        errors++;
        return;
      end
      want = pending_totals.pop_front();
      flows_checked++;
      if (flow !== want) begin
        $error("flow_total: expected %0d, actual %0d", want, flow);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [3:0]  in_from_vertex;
  logic [3:0]  in_to_vertex;
  logic [15:0] in_edge_capacity;
  logic [3:0]  in_source_vertex;
  logic [3:0]  in_sink_vertex;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] out_flow_total;

  flow_scoreboard flow_sb;
  int  items_sent;
  int  idle_pct_in;
  int  idle_pct_out;
  bit  hold_off_req;
  bit  stimulus_done;

  max_flow_augmenting_path dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_edge_capacity (in_edge_capacity),
    .in_source_vertex (in_source_vertex),
    .in_sink_vertex   (in_sink_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flow_total   (out_flow_total)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample both channels at the rising edge. An accepted input transfer is
  // folded into the scoreboard's matrix; an accepted result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        flow_sb.note_input(in_cmd, in_from_vertex, in_to_vertex, in_edge_capacity,
                           in_source_vertex, in_sink_vertex);
      if (out_valid && !out_stall) flow_sb.check_result(out_flow_total);
    end
  end

  // Offer one item and hold it until the block takes it. Random idle cycles
  // go in front of the item according to the current idle rate. Valid stays
  // high after the transfer so that a following item can go out at once.
  task automatic send_item(logic [1:0] cmd, logic [3:0] fv, logic [3:0] tv,
                           logic [15:0] cap, logic [3:0] sv, logic [3:0] kv);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_from_vertex   <= fv;
    in_to_vertex     <= tv;
    in_edge_capacity <= cap;
    in_source_vertex <= sv;
    in_sink_vertex   <= kv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_edge(int fv, int tv, int cap);
    send_item(CMD_ADD, 4'(fv), 4'(tv), 16'(cap), 4'($urandom), 4'($urandom));
  endtask

  task automatic send_compute(int sv, int kv);
    send_item(CMD_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom), 4'(sv), 4'(kv));
  endtask

  task automatic send_clear();
    send_item(CMD_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
              4'($urandom));
  endtask

  // Capacities are mostly small so that many paths form, with full-range
  // values mixed in to exercise saturation.
  function automatic int pick_capacity();
    case ($urandom_range(3))
      0:       return $urandom_range(65535);
      1:       return $urandom_range(15);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // Receiver side: random stalls, plus a long hold-off on each request that is
  // counted here in cycles while the sender keeps offering items.
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < idle_pct_out);
    end
  end

  // Stimulus: directed corners first, then random graphs of varied sizes.
  initial begin
    int nv;
    int nedges;
    flow_sb = new();
    items_sent = 0;
    idle_pct_in = 33;
    idle_pct_out = 33;
    hold_off_req = 1'b0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD;
    in_from_vertex = '0;
    in_to_vertex = '0;
    in_edge_capacity = '0;
    in_source_vertex = '0;
    in_sink_vertex = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Empty matrix, source equal to sink, and the unused command.
    send_compute(0, 15);
    send_compute(7, 7);
    send_item(CMD_SPARE, 4'hF, 4'hF, 16'hFFFF, 4'hF, 4'hF);
    // Saturating parallel edges, a self loop, extreme vertices and capacity.
    send_edge(0, 15, 16'hFFFF);
    send_edge(0, 15, 16'hFFFF);
    send_edge(15, 15, 16'hFFFF);
    send_edge(15, 0, 0);
    send_compute(0, 15);
    send_compute(15, 0);
    // A chain with a bottleneck in the middle, then saturating reverse entries.
    send_edge(0, 1, 100);
    send_edge(1, 2, 5);
    send_edge(2, 3, 100);
    send_edge(3, 2, 16'hFFFE);
    send_compute(0, 3);
    send_compute(3, 0);
    send_clear();
    // Many disjoint saturated paths push the total well past 16 bits.
    for (int i = 1; i < 15; i++) begin
      send_edge(0, i, 16'hFFFF);
      send_edge(i, 15, 16'hFFFF);
    end
    send_compute(0, 15);
    send_clear();
    send_compute(0, 15);

    // Random graphs. One stretch runs with no idling at all; one stretch
    // asks the receiver to hold off for a long time.
    while (items_sent < 1350) begin
      if (items_sent > 500 && items_sent < 700) begin
        idle_pct_in = 0;
        idle_pct_out = 0;
      end else begin
        idle_pct_in = 33;
        idle_pct_out = 33;
      end
      if (items_sent > 900 && items_sent < 920) hold_off_req = 1'b1;
      nv = ($urandom_range(7) == 0) ? 16 : $urandom_range(2, 8);
      nedges = $urandom_range(1, 3 * nv);
      if ($urandom_range(3) != 0) send_clear();
      for (int e = 0; e < nedges; e++)
        send_edge($urandom_range(nv - 1), $urandom_range(nv - 1), pick_capacity());
      if ($urandom_range(15) == 0)
        send_edge($urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 3))
        send_compute($urandom_range(nv - 1), $urandom_range(nv - 1));
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Wait for every expected total, then a short drain, then report.
  initial begin
    wait (stimulus_done);
    while (flow_sb.pending_totals.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Run covered %0d input transfers and %0d flow totals checked.",
             items_sent, flow_sb.flows_checked);
    if (flow_sb.errors == 0 && flow_sb.pending_totals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Safety net against a hang.
  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
